[src/xtea_block_cipher_defines.svh]
// Assertion macros shared by the XTEA cipher RTL.
`ifndef XTEA_BLOCK_CIPHER_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define XTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/xtea_pkg.sv]
// Types, constants and round-constant functions for the XTEA cipher.
package xtea_pkg;

    localparam int unsigned CIPHER_CYCLES = 32;
    localparam int unsigned XTEA_HALF_ROUNDS = 2 * CIPHER_CYCLES;
    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    typedef logic [3:0][31:0] t_key;

    typedef struct packed {
        logic        vld;
        logic        dec;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_stage;

    function automatic logic [31:0] f_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Running sum seen by half-round k, for either direction.
    function automatic logic [31:0] f_stage_sum(input int unsigned k, input logic dec);
        logic [31:0] steps;
        steps = 32'((k + 1) >> 1);
        if (dec) begin
            steps = 32'(CIPHER_CYCLES) - steps;
        end
        return steps * XTEA_DELTA;
    endfunction

endpackage

[src/xtea_half_round.sv]
// One registered Feistel half-round of the XTEA pipeline.
module xtea_half_round import xtea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_odd,
    input  logic [31:0] i_sum_enc,
    input  logic [31:0] i_sum_dec,
    input  t_key        i_key,
    input  t_stage      i_stage,
    output t_stage      o_stage
);

    logic        w_use_hi;
    logic [31:0] w_sum;
    logic [1:0]  w_idx;
    logic [31:0] w_src;
    logic [31:0] w_dst;
    logic [31:0] w_f;
    logic [31:0] w_res;
    t_stage      n_stage;
    t_stage      r_stage;

    always_comb begin
        w_use_hi = i_odd ^ i_stage.dec;
        w_sum    = i_stage.dec ? i_sum_dec : i_sum_enc;
        w_idx    = w_use_hi ? w_sum[12:11] : w_sum[1:0];
        w_src    = w_use_hi ? i_stage.v0 : i_stage.v1;
        w_dst    = w_use_hi ? i_stage.v1 : i_stage.v0;
        w_f      = f_mix(w_src) ^ (w_sum + i_key[w_idx]);
        w_res    = i_stage.dec ? (w_dst - w_f) : (w_dst + w_f);
        n_stage  = i_stage;
        if (w_use_hi) begin
            n_stage.v1 = w_res;
        end else begin
            n_stage.v0 = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[src/xtea_block_cipher.sv]
// Top level of the pipelined XTEA block cipher.
//
//  channel   direction  contents
//  s_axis    in         tdata: block_first, block_second; tuser: func
//  m_axis    out        tdata: out_first, out_second
//  cfg       in         key_word0..key_word3 writes, index 0..3
//
// One word enters per cycle unless input is refused; each word passes the input
// register plus one register per half-round (64 half-rounds).
// The unrolled half-round chain sets the rate: every stage advances together.
// Reset is synchronous and clears valid bits, the skid valid flag and the key.
// A stalled output word parks in a skid register; input is refused only
// while that register is full, then the whole chain holds.
`include "xtea_block_cipher_defines.svh"

module xtea_block_cipher import xtea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] block_first, [63:32] block_second
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] out_first, [63:32] out_second
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_key        r_key;
    logic        w_en;
    t_stage      w_stage [0:XTEA_HALF_ROUNDS];
    t_stage      r_in;
    logic        r_skid_vld;
    logic [63:0] r_skid_data;
    t_stage      w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (w_en) begin
            r_in.vld <= i_s_axis_tvalid;
            r_in.dec <= i_s_axis_tuser;
            r_in.v0  <= i_s_axis_tdata[31:0];
            r_in.v1  <= i_s_axis_tdata[63:32];
        end
    end

    assign w_stage[0] = r_in;

    for (genvar k = 0; k < XTEA_HALF_ROUNDS; k++) begin : g_round
        xtea_half_round u_half_round (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_odd     (1'(k % 2)),
            .i_sum_enc (f_stage_sum(k, 1'b0)),
            .i_sum_dec (f_stage_sum(k, 1'b1)),
            .i_key     (r_key),
            .i_stage   (w_stage[k]),
            .o_stage   (w_stage[k + 1])
        );
    end

    assign w_last = w_stage[XTEA_HALF_ROUNDS];

    // Park the tail word when the chain advances under a stalled output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            r_skid_vld <= !i_m_axis_tready;
        end else begin
            r_skid_vld <= w_last.vld && !i_m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_skid_data <= {w_last.v1, w_last.v0};
        end
    end

    assign o_m_axis_tvalid = r_skid_vld || w_last.vld;
    assign o_m_axis_tdata  = r_skid_vld ? r_skid_data : {w_last.v1, w_last.v0};

    `XTEA_ASSERT_NEXT(a_in_to_stage0, i_s_axis_tvalid && o_s_axis_tready, r_in.vld, "accepted word missing from input register")
    `XTEA_ASSERT_SAME(a_skid_source, $rose(r_skid_vld), $past(w_last.vld && !i_m_axis_tready), "skid filled without a stalled tail word")
    `XTEA_ASSERT_NEXT(a_hold_tail, r_skid_vld && !i_m_axis_tready, $stable(w_last.v0) && $stable(w_last.v1) && w_last.vld == $past(w_last.vld), "pipeline tail moved while stalled")
    `XTEA_ASSERT_NEXT(a_skid_drain, r_skid_vld && i_m_axis_tready, !r_skid_vld, "skid word not released after acceptance")

endmodule

[sim/tb_xtea_block_cipher.sv]
// Self-checking testbench for the pipelined XTEA cipher: predicts each word and checks the stream.
module tb_xtea_block_cipher;
    import xtea_pkg::*;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_cipher_op;

    typedef enum logic [1:0] {
        REG_KEY_WORD0,
        REG_KEY_WORD1,
        REG_KEY_WORD2,
        REG_KEY_WORD3
    } t_key_reg;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
    } t_cipher_words;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0]   key_shadow [4] = '{default: '0};
    t_cipher_words pending_words [$];

    int  burst_left = 0;
    bit  sender_gaps = 1'b0;
    logic        stall_on = 1'b0;
    logic        stall_heavy = 1'b0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [5:0]  stall_tick = '0;

    int mismatch_count = 0;
    int words_checked = 0;
    int encrypt_count = 0;
    int decrypt_count = 0;
    int keys_loaded = 0;

    xtea_block_cipher u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] block_first, [63:32] block_second
        .i_s_axis_tuser  (s_tuser),   // [0] func
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [31:0] out_first, [63:32] out_second
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #(12 * 300_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] feistel_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic t_cipher_words xtea_transform(input t_cipher_op op,
                                                     input logic [31:0] first,
                                                     input logic [31:0] second);
        logic [31:0]   v0;
        logic [31:0]   v1;
        logic [31:0]   sum;
        t_cipher_words res;
        v0 = first;
        v1 = second;
        if (op == OP_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < CIPHER_CYCLES; r++) begin
                v0 += feistel_mix(v1) ^ (sum + key_shadow[sum[1:0]]);
                sum += XTEA_DELTA;
                v1 += feistel_mix(v0) ^ (sum + key_shadow[sum[12:11]]);
            end
        end else begin
            sum = XTEA_DELTA * 32'(CIPHER_CYCLES);
            for (int r = 0; r < CIPHER_CYCLES; r++) begin
                v1 -= feistel_mix(v0) ^ (sum + key_shadow[sum[12:11]]);
                sum -= XTEA_DELTA;
                v0 -= feistel_mix(v1) ^ (sum + key_shadow[sum[1:0]]);
            end
        end
        res.first = v0;
        res.second = v1;
        return res;
    endfunction

    // Receiver: rotate a random ready pattern, refreshed whenever the tick counter wraps.
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (!stall_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= stall_pattern[stall_tick[3:0]];
            if (stall_tick == '1) begin
                if (stall_heavy) begin
                    stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0101;
                end else begin
                    stall_pattern <= 16'($urandom) | 16'($urandom);
                end
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_cipher_words want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 20) begin
                    $display("%0t: unexpected word: expected none, actual %h", $time, m_tdata);
                end
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want.first) begin
                    mismatch_count++;
                    if (mismatch_count <= 20) begin
                        $display("%0t: out_first: expected %h, actual %h",
                                 $time, want.first, m_tdata[31:0]);
                    end
                end
                if (m_tdata[63:32] !== want.second) begin
                    mismatch_count++;
                    if (mismatch_count <= 20) begin
                        $display("%0t: out_second: expected %h, actual %h",
                                 $time, want.second, m_tdata[63:32]);
                    end
                end
            end
        end
    end

    task automatic send_block(input t_cipher_op op, input logic [31:0] first,
                              input logic [31:0] second);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = sender_gaps ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {second, first};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        pending_words.push_back(xtea_transform(op, first, second));
        if (op == OP_ENCRYPT) begin
            encrypt_count++;
        end else begin
            decrypt_count++;
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
    endtask

    // Write all four key words back to back; only called with the pipeline empty.
    task automatic load_key(input logic [127:0] key);
        t_key_reg idx;
        idx = REG_KEY_WORD0;
        repeat (4) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= key[32*idx +: 32];
            key_shadow[idx] = key[32*idx +: 32];
            @(posedge clk);
            idx = idx.next();
        end
        cfg_wr_en <= 1'b0;
        keys_loaded++;
    endtask

    task automatic send_edge_blocks();
        send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_reset_key();
        sender_gaps = 1'b0;
        send_edge_blocks();
        send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        wait_for_results();
    endtask

    task automatic test_key_extremes();
        load_key({4{32'hFFFF_FFFF}});
        send_edge_blocks();
        wait_for_results();
        load_key({32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h8000_0000});
        send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(OP_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210);
        wait_for_results();
    endtask

    task automatic test_round_trip();
        t_cipher_words ct;
        load_key({$urandom, $urandom, $urandom, $urandom});
        repeat (4) begin
            ct = xtea_transform(OP_ENCRYPT, $urandom, $urandom);
            send_block(OP_DECRYPT, ct.first, ct.second);
        end
        wait_for_results();
    endtask

    task automatic test_random_keys();
        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                load_key('0);
            end else begin
                load_key({$urandom, $urandom, $urandom, $urandom});
            end
            sender_gaps = (p % 3) != 2;
            stall_on    <= (p % 3) != 2;
            stall_heavy <= 1'b0;
            repeat (120) begin
                send_block(t_cipher_op'($urandom_range(0, 1)), $urandom, $urandom);
            end
            wait_for_results();
        end
    endtask

    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        stall_on    <= 1'b1;
        stall_heavy <= 1'b1;
        repeat (60) begin
            send_block(t_cipher_op'($urandom_range(0, 1)), $urandom, $urandom);
        end
        wait_for_results();
        stall_on <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_key();
        test_key_extremes();
        test_round_trip();
        test_random_keys();
        test_output_backpressure();
        wait_for_results();
        repeat (80) @(posedge clk);
        $display("Checked %0d cipher words (%0d encrypt, %0d decrypt) across %0d key loads,",
                 words_checked, encrypt_count, decrypt_count, keys_loaded);
        $display("with sender gaps and receiver stalls, including a hard back-pressure burst.");
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[xtea_block_cipher.f]
+incdir+src
src/xtea_pkg.sv
src/xtea_half_round.sv
src/xtea_block_cipher.sv
sim/tb_xtea_block_cipher.sv
